@@ rtl/csbd_pkg.sv @@
`timescale 1ns / 1ps

package csbd_pkg;

  // Route codes carried with every result.
  typedef enum logic [1:0] {
    ROUTE_NORMAL  = 2'd0,
    ROUTE_DITHER  = 2'd1,
    ROUTE_CAPTURE = 2'd2,
    ROUTE_DROP    = 2'd3
  } route_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CAPTURE_ENABLE = 2'd0,
    REG_CAPTURE_WIDTH  = 2'd1,
    REG_CAPTURE_HEIGHT = 2'd2,
    REG_ENHANCE_ENABLE = 2'd3
  } cfg_reg_t;

  localparam int CoordW = 16;
  localparam int GrayW  = 8;
  localparam int DimW   = 11;
  localparam int AddrW  = 20;
  localparam int CfgW   = 11;

  localparam logic [GrayW-1:0] BlackLevel = 8'd30;

  // floor(g * 51 / 38) == (g * 1407345) >> 20 for every g up to 225.
  localparam logic [20:0] StretchMul = 21'd1407345;
  // (v * 15 + 127) / 255 == (v * 61695 + 522351) >> 20 for every v up to 255.
  localparam logic [15:0] QuantMul   = 16'd61695;
  localparam logic [23:0] QuantAdd   = 24'd522351;

  // 8x8 Bayer thresholds, indexed by {y[2:0], x[2:0]}.
  localparam logic [5:0] BayerTab [64] = '{
    6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
    6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
    6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
    6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
    6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
    6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
    6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
    6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
  };

  // Dither offset (t - 32) * 17 / 32, truncated toward zero.
  function automatic logic signed [5:0] dither_offset(input logic [5:0] t);
    logic       neg;
    logic [5:0] mag;
    logic [9:0] prod;
    logic [4:0] quo;
    neg  = (t < 6'd32);
    mag  = neg ? (6'd32 - t) : (t - 6'd32);
    prod = {4'd0, mag} * 10'd17;
    quo  = prod[9:5];
    return neg ? (6'sd0 - $signed({1'b0, quo})) : $signed({1'b0, quo});
  endfunction

endpackage

@@ rtl/csbd_if.sv @@
`timescale 1ns / 1ps

interface csbd_pixel_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;
  logic [7:0]         gray_in;

  modport source (output valid, pixel_x, pixel_y, gray_in, input ready);
  modport sink   (input valid, pixel_x, pixel_y, gray_in, output ready);
endinterface

interface csbd_pixel_out_if;
  logic               valid;
  logic               ready;
  csbd_pkg::route_t   route;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic [7:0]         out_value;
  logic [19:0]        capture_address;

  modport source (output valid, route, out_x, out_y, out_value, capture_address,
                  input ready);
  modport sink   (input valid, route, out_x, out_y, out_value, capture_address,
                  output ready);
endinterface

interface csbd_cfg_if;
  logic                 valid;
  logic                 ready;
  csbd_pkg::cfg_reg_t   index;
  logic [10:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/contrast_stretch_bayer_dither.sv @@
`timescale 1ns / 1ps

// Throughput: one pixel per cycle while the output is not stalled; each of the
// three stages holds its item while the stage after it cannot take it, so a
// stall on the output backs up in order. Reset (rst_n low, synchronous) clears
// all stage valid bits and all configuration registers; the configuration port
// is always ready.
module contrast_stretch_bayer_dither (
  input logic              clk,
  input logic              rst_n,
  csbd_pixel_in_if.sink    in_px,
  csbd_pixel_out_if.source out_px,
  csbd_cfg_if.sink         cfg_wr
);
  import csbd_pkg::*;

  // Configuration registers. They must be written only while the pipeline is
  // empty, a rule the block leaves to the user, so no stage needs its own copy.
  logic             cap_en_r;
  logic [DimW-1:0]  cap_w_r;
  logic [DimW-1:0]  cap_h_r;
  logic             enh_en_r;

  // Stage 1: route decision, address product, stretched gray, dither offset.
  logic                    s1_vld_r;
  route_t                  s1_route_r;
  logic signed [CoordW-1:0] s1_x_r;
  logic signed [CoordW-1:0] s1_y_r;
  logic [GrayW-1:0]        s1_gray_r;
  logic [AddrW-1:0]        s1_prod_r;
  logic [GrayW-1:0]        s1_c_r;
  logic signed [5:0]       s1_dith_r;

  // Stage 2: final address and dithered, clamped gray.
  logic                    s2_vld_r;
  route_t                  s2_route_r;
  logic signed [CoordW-1:0] s2_x_r;
  logic signed [CoordW-1:0] s2_y_r;
  logic [GrayW-1:0]        s2_gray_r;
  logic [AddrW-1:0]        s2_addr_r;
  logic [GrayW-1:0]        s2_v_r;

  // Stage 3: the output register.
  logic                    s3_vld_r;
  route_t                  s3_route_r;
  logic signed [CoordW-1:0] s3_x_r;
  logic signed [CoordW-1:0] s3_y_r;
  logic [GrayW-1:0]        s3_value_r;
  logic [AddrW-1:0]        s3_addr_r;

  // A stage loads when it is empty or when its content moves on in the same
  // cycle; this is the usual elastic chain and never drops or doubles an item.
  logic en1, en2, en3;
  assign en3 = !s3_vld_r || out_px.ready;
  assign en2 = !s2_vld_r || en3;
  assign en1 = !s1_vld_r || en2;

  assign in_px.ready  = en1;
  assign cfg_wr.ready = 1'b1;

  // ---------------- Stage 1 next values ----------------
  route_t            s1_route_nxt;
  logic [AddrW-1:0]  s1_prod_nxt;
  logic [GrayW-1:0]  s1_c_nxt;
  logic signed [5:0] s1_dith_nxt;
  logic              in_window;
  logic [GrayW-1:0]  g_off;
  logic [28:0]       stretch_prod;
  logic [8:0]        c_wide;
  logic [25:0]       addr_prod;

  always_comb begin
    // Window test: both coordinates non-negative and below the dimensions.
    in_window = !in_px.pixel_x[CoordW-1] && !in_px.pixel_y[CoordW-1] &&
                ({4'd0, cap_w_r} > in_px.pixel_x[CoordW-2:0]) &&
                ({4'd0, cap_h_r} > in_px.pixel_y[CoordW-2:0]);

    if (cap_en_r) begin
      s1_route_nxt = in_window ? ROUTE_CAPTURE : ROUTE_DROP;
    end else if (enh_en_r) begin
      s1_route_nxt = ROUTE_DITHER;
    end else begin
      s1_route_nxt = ROUTE_NORMAL;
    end

    // Row times width; only the low address bits are ever kept.
    addr_prod   = {11'd0, in_px.pixel_y[CoordW-2:0]} * {15'd0, cap_w_r};
    s1_prod_nxt = addr_prod[AddrW-1:0];

    // Stretch 30..220 onto 0..255 with a reciprocal multiply, then clamp.
    g_off        = (in_px.gray_in < BlackLevel) ? '0 : (in_px.gray_in - BlackLevel);
    stretch_prod = {21'd0, g_off} * {8'd0, StretchMul};
    c_wide       = stretch_prod[28:20];
    s1_c_nxt     = c_wide[8] ? 8'd255 : c_wide[7:0];

    // Bayer cell from the low three bits of each coordinate.
    s1_dith_nxt = dither_offset(BayerTab[{in_px.pixel_y[2:0], in_px.pixel_x[2:0]}]);
  end

  // ---------------- Stage 2 next values ----------------
  logic [AddrW-1:0]  s2_addr_nxt;
  logic [GrayW-1:0]  s2_v_nxt;
  logic signed [9:0] v_sum;

  always_comb begin
    s2_addr_nxt = (s1_route_r == ROUTE_CAPTURE) ?
                  (s1_prod_r + {5'd0, s1_x_r[CoordW-2:0]}) : '0;
    v_sum = $signed({2'b00, s1_c_r}) + 10'(s1_dith_r);
    if (v_sum < 10'sd0) begin
      s2_v_nxt = '0;
    end else if (v_sum > 10'sd255) begin
      s2_v_nxt = 8'd255;
    end else begin
      s2_v_nxt = v_sum[7:0];
    end
  end

  // ---------------- Stage 3 next values ----------------
  logic [GrayW-1:0] s3_value_nxt;
  logic [23:0]      quant_prod;
  logic [3:0]       level;

  always_comb begin
    // Sixteen levels: (v * 15 + 127) / 255 folded into one multiply-add.
    quant_prod = {8'd0, s2_v_r} * {8'd0, QuantMul} + QuantAdd;
    level      = quant_prod[23:20];
    // A level times 17 is the level repeated in both nibbles.
    s3_value_nxt = (s2_route_r == ROUTE_DITHER) ? {level, level} : s2_gray_r;
  end

  // ---------------- Control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_en_r <= 1'b0;
      cap_w_r  <= '0;
      cap_h_r  <= '0;
      enh_en_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (cfg_wr.valid) begin
        case (cfg_wr.index)
          REG_CAPTURE_ENABLE: cap_en_r <= cfg_wr.data[0];
          REG_CAPTURE_WIDTH:  cap_w_r  <= cfg_wr.data;
          REG_CAPTURE_HEIGHT: cap_h_r  <= cfg_wr.data;
          REG_ENHANCE_ENABLE: enh_en_r <= cfg_wr.data[0];
          default: ;
        endcase
      end
      if (en1) s1_vld_r <= in_px.valid;
      if (en2) s2_vld_r <= s1_vld_r;
      if (en3) s3_vld_r <= s2_vld_r;
    end
  end

  // ---------------- Payload registers ----------------
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_route_r <= s1_route_nxt;
      s1_x_r     <= in_px.pixel_x;
      s1_y_r     <= in_px.pixel_y;
      s1_gray_r  <= in_px.gray_in;
      s1_prod_r  <= s1_prod_nxt;
      s1_c_r     <= s1_c_nxt;
      s1_dith_r  <= s1_dith_nxt;
    end
    if (en2) begin
      s2_route_r <= s1_route_r;
      s2_x_r     <= s1_x_r;
      s2_y_r     <= s1_y_r;
      s2_gray_r  <= s1_gray_r;
      s2_addr_r  <= s2_addr_nxt;
      s2_v_r     <= s2_v_nxt;
    end
    if (en3) begin
      s3_route_r <= s2_route_r;
      s3_x_r     <= s2_x_r;
      s3_y_r     <= s2_y_r;
      s3_value_r <= s3_value_nxt;
      s3_addr_r  <= s2_addr_r;
    end
  end

  assign out_px.valid           = s3_vld_r;
  assign out_px.route           = s3_route_r;
  assign out_px.out_x           = s3_x_r;
  assign out_px.out_y           = s3_y_r;
  assign out_px.out_value       = s3_value_r;
  assign out_px.capture_address = s3_addr_r;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the pixel router with contrast stretch and ordered
// dither. Pixels are offered on the input channel with random gaps, results
// are taken with random back-pressure, and every result transaction is
// compared field by field against a software prediction made when its pixel
// was accepted. Register settings only change once the pipeline has drained.
module testbench;
  import csbd_pkg::*;

  // Gray level knees of the contrast stretch and the quantiser constants.
  localparam int DarkKnee    = 30;
  localparam int BrightKnee  = 220;
  localparam int FullScale   = 255;
  localparam int StepScale   = 17;
  localparam int BayerCentre = 32;
  localparam int Levels      = 15;
  localparam int RoundTerm   = 127;

  // Longest run of cycles without any transaction before the run is abandoned.
  localparam int StallLimit  = 2000;
  // Final wait after draining, long enough for any stray result to show up.
  localparam int DrainCycles = 8;
  localparam int IdlePercent = 13;

  // Ordered dither thresholds, row-major by {y[2:0], x[2:0]}.
  localparam int BayerThreshold [64] = '{
    0,  32, 8,  40, 2,  34, 10, 42,
    48, 16, 56, 24, 50, 18, 58, 26,
    12, 44, 4,  36, 14, 46, 6,  38,
    60, 28, 52, 20, 62, 30, 54, 22,
    3,  35, 11, 43, 1,  33, 9,  41,
    51, 19, 59, 27, 49, 17, 57, 25,
    15, 47, 7,  39, 13, 45, 5,  37,
    63, 31, 55, 23, 61, 29, 53, 21
  };

  typedef struct packed {
    logic        capture_en;
    logic [10:0] width;
    logic [10:0] height;
    logic        enhance_en;
  } router_settings_t;

  typedef struct packed {
    route_t             route;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         value;
    logic [19:0]        addr;
  } routed_pixel_t;

  logic clk;
  logic rst_n;

  csbd_pixel_in_if  px_in ();
  csbd_pixel_out_if px_out ();
  csbd_cfg_if       cfg ();

  contrast_stretch_bayer_dither dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (px_in),
    .out_px (px_out),
    .cfg_wr (cfg)
  );

  // Register values currently held by the block, as far as the bench knows.
  router_settings_t active;
  // Predicted results, oldest first, one per accepted pixel.
  routed_pixel_t    pending_pixels [$];

  int  errors;
  int  pixels_sent;
  int  settings_applied;
  int  route_seen [4];
  int  stall_cycles;
  // When set, neither side inserts gaps or back-pressure.
  bit  no_idle;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    errors++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [19:0] want,
                             input logic [19:0] got);
    if (want !== got)
      report_error($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
  endtask

  // Works out the single result that one pixel causes under the given
  // register values.
  function automatic routed_pixel_t predict_pixel(input router_settings_t s,
                                                  input logic signed [15:0] x,
                                                  input logic signed [15:0] y,
                                                  input logic [7:0] gray);
    routed_pixel_t r;
    int            xi;
    int            yi;
    int            stretched;
    int            thr;
    int            offset;
    int            level_in;
    longint        addr;
    xi      = x;
    yi      = y;
    r.x     = x;
    r.y     = y;
    r.value = gray;
    r.addr  = '0;
    if (s.capture_en) begin
      if (xi >= 0 && yi >= 0 && xi < int'(s.width) && yi < int'(s.height)) begin
        r.route = ROUTE_CAPTURE;
        addr    = longint'(yi) * longint'(s.width) + longint'(xi);
        r.addr  = addr[19:0];
      end else begin
        r.route = ROUTE_DROP;
      end
    end else if (!s.enhance_en) begin
      r.route = ROUTE_NORMAL;
    end else begin
      r.route = ROUTE_DITHER;
      if (int'(gray) < DarkKnee) begin
        stretched = 0;
      end else begin
        stretched = (int'(gray) - DarkKnee) * FullScale / (BrightKnee - DarkKnee);
      end
      if (stretched > FullScale) stretched = FullScale;
      thr = BayerThreshold[{y[2:0], x[2:0]}] - BayerCentre;
      // Division by 32 rounds toward zero on both sides of the centre.
      if (thr < 0) offset = -((-thr) * StepScale / 32);
      else offset = thr * StepScale / 32;
      level_in = stretched + offset;
      if (level_in < 0) level_in = 0;
      if (level_in > FullScale) level_in = FullScale;
      r.value = 8'(((level_in * Levels + RoundTerm) / FullScale) * StepScale);
    end
    return r;
  endfunction

  // Offers one pixel and waits for its transaction. On return valid is still
  // high with the accepted pixel, so the caller must either send another pixel
  // or call drain_pixels before time moves on.
  task automatic send_pixel(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic [7:0] gray);
    while (!no_idle && $urandom_range(99) < IdlePercent) begin
      px_in.valid <= 1'b0;
      @(posedge clk);
    end
    px_in.valid   <= 1'b1;
    px_in.pixel_x <= x;
    px_in.pixel_y <= y;
    px_in.gray_in <= gray;
    do @(posedge clk); while (!px_in.ready);
    pending_pixels.push_back(predict_pixel(active, x, y, gray));
    pixels_sent++;
  endtask

  // Stops offering pixels and waits until every predicted result has arrived.
  task automatic drain_pixels();
    px_in.valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [10:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
  endtask

  // Writes all four registers back to back; only called with the pipeline
  // empty.
  task automatic apply_settings(input router_settings_t s);
    cfg_write(REG_CAPTURE_ENABLE, {10'd0, s.capture_en});
    cfg_write(REG_CAPTURE_WIDTH, s.width);
    cfg_write(REG_CAPTURE_HEIGHT, s.height);
    cfg_write(REG_ENHANCE_ENABLE, {10'd0, s.enhance_en});
    cfg.valid <= 1'b0;
    active = s;
    settings_applied++;
  endtask

  // Straight after reset every register is zero, so pixels pass unchanged.
  task automatic test_reset_passthrough();
    send_pixel(16'sd0, 16'sd0, 8'd0);
    send_pixel(-16'sd32768, 16'sd32767, 8'd255);
    send_pixel(16'sd32767, -16'sd32768, 8'd170);
    send_pixel(-16'sd1, -16'sd1, 8'd85);
    drain_pixels();
  endtask

  // Stretch knees, both clamps and Bayer cells picked by negative coordinates.
  task automatic test_dither_edges();
    apply_settings('{1'b0, 11'd0, 11'd0, 1'b1});
    send_pixel(16'sd0, 16'sd0, 8'd0);
    send_pixel(16'sd7, 16'sd7, 8'd255);
    send_pixel(-16'sd1, -16'sd1, 8'd29);
    send_pixel(-16'sd8, 16'sd3, 8'd30);
    send_pixel(16'sd3, -16'sd5, 8'd31);
    send_pixel(-16'sd32768, 16'sd32767, 8'd219);
    send_pixel(16'sd32767, -16'sd32768, 8'd220);
    send_pixel(16'sd1, 16'sd1, 8'd221);
    send_pixel(16'sd5, 16'sd2, 8'd128);
    drain_pixels();
  endtask

  // Window edges on each side, negative coordinates, and capture winning over
  // enhancement.
  task automatic test_capture_window();
    apply_settings('{1'b1, 11'd640, 11'd480, 1'b0});
    send_pixel(16'sd0, 16'sd0, 8'd12);
    send_pixel(16'sd639, 16'sd479, 8'd255);
    send_pixel(16'sd640, 16'sd0, 8'd1);
    send_pixel(16'sd0, 16'sd480, 8'd2);
    send_pixel(-16'sd1, 16'sd5, 8'd3);
    send_pixel(16'sd5, -16'sd1, 8'd4);
    send_pixel(-16'sd32768, -16'sd32768, 8'd0);
    send_pixel(16'sd32767, 16'sd32767, 8'd200);
    drain_pixels();
    apply_settings('{1'b1, 11'd640, 11'd480, 1'b1});
    send_pixel(16'sd10, 16'sd10, 8'd100);
    drain_pixels();
  endtask

  // A zero width or a zero height means every pixel is dropped.
  task automatic test_empty_window();
    apply_settings('{1'b1, 11'd0, 11'd8, 1'b0});
    send_pixel(16'sd0, 16'sd0, 8'd77);
    drain_pixels();
    apply_settings('{1'b1, 11'd8, 11'd0, 1'b0});
    send_pixel(16'sd0, 16'sd0, 8'd78);
    drain_pixels();
  endtask

  // Oversized buffers push the address past 20 bits, where it wraps.
  task automatic test_address_wrap();
    apply_settings('{1'b1, 11'd2047, 11'd2047, 1'b0});
    send_pixel(16'sd2046, 16'sd2046, 8'd99);
    send_pixel(16'sd1000, 16'sd1500, 8'd98);
    drain_pixels();
  endtask

  function automatic logic [10:0] pick_dimension();
    case ($urandom_range(5))
      0: return 11'd0;
      1: return 11'd1;
      2: return 11'd1024;
      3: return 11'd2047;
      4: return 11'($urandom_range(2047));
      default: return 11'($urandom_range(1, 64));
    endcase
  endfunction

  // With capture on, most pixels land in or just beyond the window so that
  // both capture and drop stay busy; the rest use the full coordinate range.
  task automatic send_random_pixel();
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         gray;
    x    = 16'($urandom_range(65535));
    y    = 16'($urandom_range(65535));
    gray = 8'($urandom_range(255));
    if (active.capture_en && $urandom_range(9) < 8) begin
      x = 16'($urandom_range(int'(active.width) + 1));
      y = 16'($urandom_range(int'(active.height) + 1));
    end
    if ($urandom_range(4) == 0) begin
      if ($urandom_range(1) == 0) gray = 8'($urandom_range(20, 40));
      else gray = 8'($urandom_range(210, 230));
    end
    send_pixel(x, y, gray);
  endtask

  // Twelve phases of random pixels under changing register values. The first
  // three phases pin the extremes; one phase runs with no gaps at all, and in
  // odd phases the sender holds off midway until the pipeline is empty.
  task automatic test_random_stream();
    router_settings_t s;
    int               phase;
    int               n;
    for (phase = 0; phase < 12; phase++) begin
      case (phase)
        0: s = '{1'b1, 11'd2047, 11'd2047, 1'b1};
        1: s = '{1'b0, 11'd0, 11'd0, 1'b1};
        2: s = '{1'b1, 11'd0, 11'd0, 1'b0};
        default: begin
          s.capture_en = 1'($urandom_range(1));
          s.width      = pick_dimension();
          s.height     = pick_dimension();
          s.enhance_en = 1'($urandom_range(1));
        end
      endcase
      no_idle = (phase == 4);
      apply_settings(s);
      for (n = 0; n < 125; n++) begin
        if (n == 60 && phase % 2 == 1) drain_pixels();
        send_random_pixel();
      end
      drain_pixels();
    end
    no_idle = 1'b0;
  endtask

  // Result side: takes each result transaction, compares it with the oldest
  // prediction, then decides whether to apply back-pressure next cycle.
  always @(posedge clk) begin : check_results
    routed_pixel_t want;
    if (rst_n && px_out.valid && px_out.ready) begin
      if (pending_pixels.size() == 0) begin
        report_error($sformatf("result transaction with no pixel pending, x %0d y %0d",
                               px_out.out_x, px_out.out_y));
      end else begin
        want = pending_pixels.pop_front();
        check_field("route", 20'(want.route), 20'(px_out.route));
        check_field("out_x", 20'(want.x[15:0]), 20'(px_out.out_x[15:0]));
        check_field("out_y", 20'(want.y[15:0]), 20'(px_out.out_y[15:0]));
        check_field("out_value", 20'(want.value), 20'(px_out.out_value));
        check_field("capture_address", want.addr, px_out.capture_address);
        route_seen[want.route]++;
      end
    end
    px_out.ready <= no_idle || ($urandom_range(99) >= IdlePercent);
  end

  // Watchdog: any transaction on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (px_in.valid && px_in.ready) || (px_out.valid && px_out.ready)
        || (cfg.valid && cfg.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, StallLimit);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    px_in.valid   = 1'b0;
    px_in.pixel_x = '0;
    px_in.pixel_y = '0;
    px_in.gray_in = '0;
    px_out.ready  = 1'b0;
    cfg.valid     = 1'b0;
    cfg.index     = REG_CAPTURE_ENABLE;
    cfg.data      = '0;
    active        = '0;
    no_idle       = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_passthrough();
    test_dither_edges();
    test_capture_window();
    test_empty_window();
    test_address_wrap();
    test_random_stream();

    drain_pixels();
    // Anything arriving now would be a result without a pixel behind it.
    repeat (DrainCycles) @(posedge clk);
    if (pending_pixels.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_pixels.size()));

    $display("summary: %0d pixels under %0d register settings", pixels_sent,
             settings_applied);
    $display("summary: routes normal %0d, dithered %0d, captured %0d, dropped %0d",
             route_seen[0], route_seen[1], route_seen[2], route_seen[3]);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
